// File: rtl/quoted_argument_tokenizer_core_assert.svh
// Assertion macros for the quoted argument tokenizer.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef QUOTED_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH

`define QAT_ASSERT_SAME(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("qat: same-cycle check failed");

`define QAT_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("qat: next-cycle check failed");

`endif

// File: rtl/qat_pkg.sv
// Shared types and constants for the quoted argument tokenizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qat_pkg;

  localparam int MAX_ARGS    = 32;
  localparam int MAX_ARG_LEN = 256;
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int COUNT_W = $clog2(MAX_RESULTS + 1);
  localparam int BEAT_W  = $clog2(MAX_RESULTS);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] ARGS_LIMIT = 6'(MAX_ARGS);
  localparam logic [8:0] LEN_LIMIT  = 9'(MAX_ARG_LEN - 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [3:0] ERR_BAD_QUOTE = 4'b0001;
  localparam logic [3:0] ERR_UNCLOSED  = 4'b0010;
  localparam logic [3:0] ERR_ESCAPE    = 4'b0100;
  localparam logic [3:0] ERR_OVERFLOW  = 4'b1000;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_END       = 2'd1,
    KIND_BAD_QUOTE = 2'd2,
    KIND_FINISH    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic [5:0] arg_index;
    logic [5:0] arg_total;
    logic [3:0] error_flags;
    logic       end_of_run;
  } out_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         count;
    out_t [MAX_RESULTS-1:0]     beats;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/quoted_argument_tokenizer_core.sv
// Top level of the quoted argument tokenizer: front end, bundle queue, back end.
// Depends on qat_pkg, qat_front, qat_queue, qat_back and the assertion header.
//
// One character is accepted per cycle while the queue is not full. The front
// end turns each character into a bundle of zero to four result beats in the
// same cycle and writes each non-empty bundle into a four-entry queue; the back
// end sends one beat per cycle while result_stall is low. A character that
// produces no beat writes nothing into the queue. Input stalls only while the
// queue holds four bundles, so one character is accepted per cycle as long as
// the back end drains bundles as fast as they are written; each beat is sent.
`timescale 1ns / 1ps
`default_nettype none

`include "quoted_argument_tokenizer_core_assert.svh"

module quoted_argument_tokenizer_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire qat_pkg::in_t   item,
  output logic                result_valid,
  input  wire logic           result_stall,
  output qat_pkg::out_t       result
);

  logic                   push;
  logic                   pop;
  qat_pkg::bundle_t       push_data;
  qat_pkg::bundle_t       head;
  qat_pkg::queue_status_t q_status;

  qat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .bundle     (push_data)
  );

  qat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  qat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `QAT_ASSERT_SAME(a_no_push_when_full, push, !q_status.full)
  `QAT_ASSERT_SAME(a_finish_ends_run, result_valid && (result.kind == qat_pkg::KIND_FINISH), result.end_of_run)
  `QAT_ASSERT_SAME(a_char_only_on_append, result_valid && (result.kind != qat_pkg::KIND_CHAR), result.out_char == 8'd0)
  `QAT_ASSERT_NEXT(a_pop_frees_slot, q_status.full && pop && !push, !q_status.full)

endmodule

`default_nettype wire

// File: rtl/qat_front.sv
// Front end: accepts characters, runs the tokenizer state and builds one
// bundle of result beats per character. Depends on qat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qat_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire qat_pkg::in_t           item,
  input  wire qat_pkg::queue_status_t q_status,
  output logic                        push,
  output qat_pkg::bundle_t            bundle
);

  logic       inside_token, inside_token_next;
  logic       inside_quote, inside_quote_next;
  logic       escape_pending, escape_pending_next;
  logic       quote_is_double, quote_is_double_next;
  logic       held_backslash, held_backslash_next;
  logic [5:0] args_done, args_done_next;
  logic [8:0] char_position, char_position_next;
  logic [3:0] sticky_errors, sticky_errors_next;

  logic                          accept;
  logic [7:0]                    c;
  logic [7:0]                    closer;
  logic                          app_a, app_b, end_b, bad_b;
  logic                          is_blank, is_quote;
  logic [3:0]                    fin_flags;
  logic [qat_pkg::COUNT_W-1:0]   n, n_m1;
  qat_pkg::out_t [qat_pkg::MAX_RESULTS-1:0] beats;

  function automatic qat_pkg::out_t make_beat(qat_pkg::kind_t k, logic [7:0] ch,
                                              logic [5:0] idx, logic [3:0] flags);
    qat_pkg::out_t b;
    b.kind        = k;
    b.out_char    = ch;
    b.arg_index   = idx;
    b.arg_total   = idx;
    b.error_flags = flags;
    b.end_of_run  = 1'b0;
    return b;
  endfunction

  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    inside_token_next    = inside_token;
    inside_quote_next    = inside_quote;
    escape_pending_next  = escape_pending;
    quote_is_double_next = quote_is_double;
    held_backslash_next  = held_backslash;
    args_done_next       = args_done;
    char_position_next   = char_position;
    sticky_errors_next   = sticky_errors;
    beats     = '0;
    n         = '0;
    app_a     = 1'b0;
    app_b     = 1'b0;
    end_b     = 1'b0;
    bad_b     = 1'b0;
    fin_flags = '0;
    c         = item.ch;
    closer    = quote_is_double ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE;
    is_blank  = (c == qat_pkg::CH_SPACE) || (c == qat_pkg::CH_TAB) || (c == qat_pkg::CH_NL);
    is_quote  = (c == qat_pkg::CH_SQUOTE) || (c == qat_pkg::CH_DQUOTE);

    // A backslash held inside quotes is settled by the character after it.
    if (held_backslash) begin
      held_backslash_next = 1'b0;
      if ((inside_quote && (c != closer)) || escape_pending) begin
        app_a = 1'b1;
      end else begin
        escape_pending_next = 1'b1;
      end
    end

    if (is_blank) begin
      if (inside_token) begin
        if (inside_quote) begin
          app_b = 1'b1;
        end else if (escape_pending_next) begin
          escape_pending_next = 1'b0;
          app_b = 1'b1;
        end else begin
          inside_token_next = 1'b0;
          end_b = 1'b1;
        end
      end
    end else if (is_quote) begin
      if (escape_pending_next) begin
        app_b = 1'b1;
        escape_pending_next = 1'b0;
      end else if (!inside_token) begin
        inside_token_next    = 1'b1;
        inside_quote_next    = 1'b1;
        quote_is_double_next = (c == qat_pkg::CH_DQUOTE);
      end else if (inside_quote) begin
        if (c == closer) begin
          inside_quote_next = 1'b0;
          inside_token_next = 1'b0;
          end_b = 1'b1;
        end else begin
          app_b = 1'b1;
        end
      end else begin
        bad_b = 1'b1;
      end
    end else if (c == qat_pkg::CH_BSLASH) begin
      if (inside_quote) begin
        if (item.last) begin
          app_b = 1'b1;
        end else begin
          held_backslash_next = 1'b1;
        end
      end else if (escape_pending_next) begin
        app_b = 1'b1;
      end else begin
        escape_pending_next = 1'b1;
      end
    end else begin
      inside_token_next = 1'b1;
      app_b = 1'b1;
      end_b = item.last;
    end

    if (app_a) begin
      if ((args_done_next >= qat_pkg::ARGS_LIMIT) || (char_position_next >= qat_pkg::LEN_LIMIT)) begin
        sticky_errors_next = sticky_errors_next | qat_pkg::ERR_OVERFLOW;
      end else begin
        beats[n[qat_pkg::BEAT_W-1:0]] = make_beat(qat_pkg::KIND_CHAR, qat_pkg::CH_BSLASH,
                                                  args_done_next, sticky_errors_next);
        n = n + 1'b1;
        char_position_next = char_position_next + 9'd1;
      end
    end

    if (app_b) begin
      if ((args_done_next >= qat_pkg::ARGS_LIMIT) || (char_position_next >= qat_pkg::LEN_LIMIT)) begin
        sticky_errors_next = sticky_errors_next | qat_pkg::ERR_OVERFLOW;
      end else begin
        beats[n[qat_pkg::BEAT_W-1:0]] = make_beat(qat_pkg::KIND_CHAR, c,
                                                  args_done_next, sticky_errors_next);
        n = n + 1'b1;
        char_position_next = char_position_next + 9'd1;
      end
    end

    if (end_b) begin
      char_position_next = '0;
      if (args_done_next >= qat_pkg::ARGS_LIMIT) begin
        sticky_errors_next = sticky_errors_next | qat_pkg::ERR_OVERFLOW;
      end else begin
        beats[n[qat_pkg::BEAT_W-1:0]] = make_beat(qat_pkg::KIND_END, 8'd0,
                                                  args_done_next, sticky_errors_next);
        n = n + 1'b1;
        args_done_next = args_done_next + 6'd1;
      end
    end

    if (bad_b) begin
      sticky_errors_next = sticky_errors_next | qat_pkg::ERR_BAD_QUOTE;
      beats[n[qat_pkg::BEAT_W-1:0]] = make_beat(qat_pkg::KIND_BAD_QUOTE, 8'd0,
                                                args_done_next, sticky_errors_next);
      n = n + 1'b1;
    end

    if (item.last) begin
      fin_flags = sticky_errors_next
                | (inside_quote_next   ? qat_pkg::ERR_UNCLOSED : 4'd0)
                | (escape_pending_next ? qat_pkg::ERR_ESCAPE   : 4'd0);
      beats[n[qat_pkg::BEAT_W-1:0]] = make_beat(qat_pkg::KIND_FINISH, 8'd0,
                                                args_done_next, fin_flags);
      n = n + 1'b1;
      inside_token_next    = 1'b0;
      inside_quote_next    = 1'b0;
      escape_pending_next  = 1'b0;
      quote_is_double_next = 1'b0;
      held_backslash_next  = 1'b0;
      args_done_next       = '0;
      char_position_next   = '0;
      sticky_errors_next   = '0;
    end

    n_m1 = n - 1'b1;
    if (n != '0) begin
      beats[n_m1[qat_pkg::BEAT_W-1:0]].end_of_run = 1'b1;
    end
  end

  assign push         = accept && (n != '0);
  assign bundle.count = n;
  assign bundle.beats = beats;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_token    <= 1'b0;
      inside_quote    <= 1'b0;
      escape_pending  <= 1'b0;
      quote_is_double <= 1'b0;
      held_backslash  <= 1'b0;
      args_done       <= '0;
      char_position   <= '0;
      sticky_errors   <= '0;
    end else if (accept) begin
      inside_token    <= inside_token_next;
      inside_quote    <= inside_quote_next;
      escape_pending  <= escape_pending_next;
      quote_is_double <= quote_is_double_next;
      held_backslash  <= held_backslash_next;
      args_done       <= args_done_next;
      char_position   <= char_position_next;
      sticky_errors   <= sticky_errors_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/qat_queue.sv
// Bundle queue between the front end and the back end of the tokenizer.
// Depends on qat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qat_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire qat_pkg::bundle_t       push_data,
  input  wire logic                   pop,
  output qat_pkg::bundle_t            head,
  output qat_pkg::queue_status_t      status
);

  qat_pkg::bundle_t               entries [qat_pkg::QUEUE_DEPTH];
  logic [qat_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [qat_pkg::QCNT_W-1:0]     fill;

  assign status.full  = (fill == qat_pkg::QCNT_W'(qat_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/qat_back.sv
// Back end: plays out the beats of the bundle at the queue head, one a cycle
// while result_stall is low. Depends on qat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qat_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire qat_pkg::bundle_t       head,
  input  wire qat_pkg::queue_status_t q_status,
  output logic                        pop,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output qat_pkg::out_t               result
);

  logic [qat_pkg::BEAT_W-1:0]  beat_idx;
  logic                        accept;
  logic                        last_beat;

  assign result_valid = !q_status.empty;
  assign result       = head.beats[beat_idx];
  assign accept       = result_valid && !result_stall;
  assign last_beat    = ({1'b0, beat_idx} + 1'b1) == head.count;
  assign pop          = accept && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx <= '0;
    end else if (pop) begin
      beat_idx <= '0;
    end else if (accept) begin
      beat_idx <= beat_idx + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: dv/quoted_argument_tokenizer_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for quoted_argument_tokenizer_core: directed strings, overflow
// strings and random command lines, with random idling on both channels.
// Depends on qat_pkg and the tokenizer RTL; result beats are predicted in-line.
module quoted_argument_tokenizer_core_test;
  import qat_pkg::*;

  typedef logic [7:0] char_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  logic tok_open = 1'b0;
  logic quote_open = 1'b0;
  logic escape_armed = 1'b0;
  logic quote_double = 1'b0;
  logic backslash_held = 1'b0;
  logic [5:0] args_count = '0;
  logic [8:0] arg_length = '0;
  logic [3:0] error_bits = '0;

  out_t step_beats[$];
  out_t expected_beats[$];
  out_t want;
  int failures = 0;
  int stall_left = 0;
  int chars_sent = 0;
  bit no_idle = 1'b0;

  quoted_argument_tokenizer_core u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic void emit_beat(kind_t k, logic [7:0] c, logic [3:0] flags);
    out_t b;
    if (step_beats.size() < MAX_RESULTS) begin
      b.kind = k;
      b.out_char = c;
      b.arg_index = args_count;
      b.arg_total = args_count;
      b.error_flags = flags;
      b.end_of_run = 1'b0;
      step_beats.push_back(b);
    end
  endfunction

  function automatic void append_to_arg(logic [7:0] c);
    if (args_count >= ARGS_LIMIT || arg_length >= LEN_LIMIT) begin
      error_bits |= ERR_OVERFLOW;
    end else begin
      emit_beat(KIND_CHAR, c, error_bits);
      arg_length = arg_length + 9'd1;
    end
  endfunction

  function automatic void close_arg();
    arg_length = '0;
    if (args_count >= ARGS_LIMIT) begin
      error_bits |= ERR_OVERFLOW;
    end else begin
      emit_beat(KIND_END, 8'h00, error_bits);
      args_count = args_count + 6'd1;
    end
  endfunction

  // A backslash inside quotes is held for one character so that an escaped
  // closing quote can be told apart from a literal backslash.
  function automatic void tokenize_char(logic [7:0] c, logic fin);
    logic [7:0] closer;
    logic [3:0] flags;
    closer = quote_double ? CH_DQUOTE : CH_SQUOTE;
    step_beats.delete();
    if (backslash_held) begin
      backslash_held = 1'b0;
      if (quote_open && c != closer) append_to_arg(CH_BSLASH);
      else if (escape_armed) append_to_arg(CH_BSLASH);
      else escape_armed = 1'b1;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      if (tok_open) begin
        if (quote_open) begin
          append_to_arg(c);
        end else if (escape_armed) begin
          escape_armed = 1'b0;
          append_to_arg(c);
        end else begin
          tok_open = 1'b0;
          close_arg();
        end
      end
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      if (escape_armed) begin
        append_to_arg(c);
        escape_armed = 1'b0;
      end else if (!tok_open) begin
        tok_open = 1'b1;
        quote_open = 1'b1;
        quote_double = (c == CH_DQUOTE);
      end else if (quote_open) begin
        if (c == closer) begin
          quote_open = 1'b0;
          tok_open = 1'b0;
          close_arg();
        end else begin
          append_to_arg(c);
        end
      end else begin
        error_bits |= ERR_BAD_QUOTE;
        emit_beat(KIND_BAD_QUOTE, 8'h00, error_bits);
      end
    end else if (c == CH_BSLASH) begin
      if (quote_open) begin
        if (fin) append_to_arg(c);
        else backslash_held = 1'b1;
      end else if (escape_armed) begin
        append_to_arg(c);
      end else begin
        escape_armed = 1'b1;
      end
    end else begin
      tok_open = 1'b1;
      append_to_arg(c);
      if (fin) close_arg();
    end
    if (fin) begin
      flags = error_bits;
      if (quote_open) flags |= ERR_UNCLOSED;
      if (escape_armed) flags |= ERR_ESCAPE;
      emit_beat(KIND_FINISH, 8'h00, flags);
      tok_open = 1'b0;
      quote_open = 1'b0;
      escape_armed = 1'b0;
      quote_double = 1'b0;
      backslash_held = 1'b0;
      args_count = '0;
      arg_length = '0;
      error_bits = '0;
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].end_of_run = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic fin);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{ch: c, last: fin};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    chars_sent++;
    tokenize_char(c, fin);
  endtask

  task automatic send_string(input char_q_t chars);
    foreach (chars[i]) send_beat(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    char_q_t chars;
    foreach (s[i]) chars.push_back(s[i]);
    send_string(chars);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] noisy_char();
    case ($urandom_range(0, 7))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_SQUOTE;
      4: return CH_DQUOTE;
      5: return CH_BSLASH;
      6: return 8'($urandom_range(97, 122));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_quote_handling();
    send_text("a\t'b c'");
    send_text("'x\\'");
    send_text("\"a\\b\\");
  endtask

  task automatic test_escape_cases();
    send_text("\\'a\"b");
    send_text("\\\\z\n");
  endtask

  task automatic test_char_extremes();
    char_q_t chars;
    chars = {8'hFF, 8'h00, 8'h80, 8'h7F, CH_BSLASH};
    send_string(chars);
  endtask

  task automatic test_length_overflow();
    char_q_t chars;
    repeat (260) chars.push_back(8'h78);
    chars.push_back(CH_SPACE);
    chars.push_back(8'h79);
    send_string(chars);
  endtask

  task automatic test_count_overflow();
    char_q_t chars;
    repeat (33) begin
      chars.push_back(8'h61);
      chars.push_back(CH_SPACE);
    end
    chars.push_back(8'h61);
    send_string(chars);
    wait_for_results();
  endtask

  task automatic test_random_commands();
    char_q_t chars;
    logic [7:0] q;
    int strings;
    int target;
    strings = 0;
    target = chars_sent + 160;
    while (chars_sent < target) begin
      chars.delete();
      no_idle = (strings % 12) >= 9;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) chars.push_back(noisy_char());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 4))
            0, 1: begin
              repeat ($urandom_range(1, 4)) chars.push_back(plain_char());
            end
            2: begin
              q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
              chars.push_back(q);
              repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 5))
                  0: chars.push_back(CH_SPACE);
                  1: chars.push_back(CH_BSLASH);
                  2: chars.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                  default: chars.push_back(plain_char());
                endcase
              end
              if ($urandom_range(0, 6) != 0) chars.push_back(q);
            end
            default: begin
              chars.push_back(CH_BSLASH);
              chars.push_back(noisy_char());
            end
          endcase
          repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 3))
              0: chars.push_back(CH_TAB);
              1: chars.push_back(CH_NL);
              default: chars.push_back(CH_SPACE);
            endcase
          end
        end
        if ($urandom_range(0, 1) == 0) void'(chars.pop_back());
      end
      send_string(chars);
      strings++;
      if (strings % 15 == 0) wait_for_results();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_beats.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: kind=%0d char=%h index=%0d total=%0d err=%h",
                   result.kind, result.out_char, result.arg_index, result.arg_total,
                   result.error_flags);
      end else begin
        want = expected_beats.pop_front();
        if (result.kind !== want.kind || result.out_char !== want.out_char ||
            result.arg_index !== want.arg_index || result.arg_total !== want.arg_total ||
            result.error_flags !== want.error_flags ||
            result.end_of_run !== want.end_of_run) begin
          failures++;
          if (failures <= 10) begin
            $display("result mismatch: expected kind=%0d char=%h index=%0d total=%0d err=%h last=%b",
                     want.kind, want.out_char, want.arg_index, want.arg_total,
                     want.error_flags, want.end_of_run);
            $display("                 got kind=%0d char=%h index=%0d total=%0d err=%h last=%b",
                     result.kind, result.out_char, result.arg_index, result.arg_total,
                     result.error_flags, result.end_of_run);
          end
        end
      end
    end
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_idle();
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_quote_handling();
    test_escape_cases();
    test_char_extremes();
    test_length_overflow();
    test_count_overflow();
    test_random_commands();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (failures == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
